@@ rtl/sacl_pkg.sv @@
// ----------------------------------------------------------------------------
// sacl_pkg: shared types and constants of the cache tag controller.
// Holds the controller state encoding, the command and status bundles
// between controller and datapath, and the register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

    localparam int STAMP_W   = 48;
    localparam int TOTAL_W   = 32;
    localparam int LAT_W     = 9;
    localparam int MAX_BYTES = 8;

    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [1:0] CFG_WRITE_THROUGH  = 2'd0;
    localparam logic [1:0] CFG_WRITE_ALLOCATE = 2'd1;
    localparam logic [1:0] CFG_BUS_DELAY      = 2'd2;
    localparam logic [1:0] CFG_HIT_DELAY      = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } state_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_valid;
    } sts_t;

endpackage

`default_nettype wire

@@ rtl/sacl_ram.sv @@
// ----------------------------------------------------------------------------
// sacl_ram: generic single-write, single-read RAM.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/sacl_ctrl.sv @@
// ----------------------------------------------------------------------------
// sacl_ctrl: sequencing state machine of the cache tag controller.
// Runs the clearing pass after reset, takes one request, and commits it
// once the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic           out_stall,
    input  wire sacl_pkg::sts_t sts,
    output sacl_pkg::cmd_t      cmd
);

    import sacl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.clear   = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (!sts.out_valid || !out_stall)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/sacl_dp.sv @@
// ----------------------------------------------------------------------------
// sacl_dp: datapath of the cache tag controller.
// Holds the tag and metadata memories, way match, replacement choice,
// statistics counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_dp #(
    parameter int SETS        = 64,
    parameter int WAYS        = 4,
    parameter int BLOCK_BYTES = 64,
    parameter int ADDR_BITS   = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sacl_pkg::cmd_t cmd,
    output sacl_pkg::sts_t      sts,
    input  wire logic           write_through_mode,
    input  wire logic           write_allocate_mode,
    input  wire logic [7:0]     bus_delay,
    input  wire logic [7:0]     hit_delay,
    input  wire logic [63:0]    address,
    input  wire logic           is_write,
    input  wire logic [3:0]     byte_count,
    input  wire logic           out_stall,
    output logic                out_valid,
    output logic                hit,
    output logic [1:0]          way_used,
    output logic                filled,
    output logic                victim_dirty,
    output logic                lower_access,
    output logic [8:0]          own_latency,
    output logic                bad_access,
    output logic [31:0]         access_total,
    output logic [31:0]         miss_total,
    output logic [31:0]         time_total
);

    import sacl_pkg::*;

    localparam int OFF_W   = $clog2(BLOCK_BYTES);
    localparam int SET_W   = $clog2(SETS);
    localparam int SET_IW  = (SET_W > 0) ? SET_W : 1;
    localparam int TAG_RAW = ADDR_BITS - OFF_W - SET_W;
    localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int META_W  = STAMP_W + 2;
    localparam int SUM_W   = OFF_W + 1;

    logic [ADDR_BITS-1:0] addr_reg;
    logic                 wr_reg;
    logic [3:0]           cnt_reg;

    logic [ADDR_BITS-1:0] in_blk;
    logic [SET_IW-1:0]    set_in;
    logic [ADDR_BITS-1:0] cur_blk;
    logic [SET_IW-1:0]    set_cur;
    logic [ADDR_BITS-1:0] tag_full;
    logic [TAG_W-1:0]     tag_cur;
    logic [OFF_W-1:0]     offset;
    logic [SUM_W-1:0]     end_sum;
    logic                 bad;

    logic [SET_IW-1:0]    clr_cnt_reg;

    logic [TAG_W-1:0]     tag_rd  [WAYS];
    logic [META_W-1:0]    meta_rd [WAYS];
    logic [STAMP_W:0]     lru_key [WAYS];
    logic [WAYS-1:0]      match;

    logic                 hit_any;
    logic [WAY_W-1:0]     hit_way;
    logic [WAY_W-1:0]     victim;
    logic [STAMP_W:0]     best_key;
    logic                 do_fill;
    logic                 update;
    logic [WAY_W-1:0]     upd_way;
    logic                 new_dirty;
    logic [META_W-1:0]    meta_wdata;
    logic [SET_IW-1:0]    waddr;
    logic [8:0]           lat;
    logic                 vdirty;
    logic                 lower;

    logic [STAMP_W-1:0]   acc_reg;
    logic [STAMP_W-1:0]   acc_next;
    logic [TOTAL_W-1:0]   miss_reg;
    logic [TOTAL_W-1:0]   miss_next;
    logic [TOTAL_W-1:0]   lsum_reg;
    logic [TOTAL_W-1:0]   lsum_next;
    logic [TOTAL_W:0]     lsum_wide;

    logic                 out_valid_reg;
    logic                 hit_reg;
    logic [1:0]           way_reg;
    logic                 filled_reg;
    logic                 vdirty_reg;
    logic                 lower_reg;
    logic [8:0]           lat_reg;
    logic                 bad_reg;
    logic [TOTAL_W-1:0]   acc_out_reg;
    logic [TOTAL_W-1:0]   miss_out_reg;
    logic [TOTAL_W-1:0]   lsum_out_reg;

    assign in_blk   = address[ADDR_BITS-1:0] >> OFF_W;
    assign set_in   = in_blk[SET_IW-1:0] & SET_IW'(SETS - 1);
    assign cur_blk  = addr_reg >> OFF_W;
    assign set_cur  = cur_blk[SET_IW-1:0] & SET_IW'(SETS - 1);
    assign tag_full = addr_reg >> (OFF_W + SET_W);
    assign tag_cur  = tag_full[TAG_W-1:0];
    assign offset   = addr_reg[OFF_W-1:0];
    assign end_sum  = SUM_W'(offset) + SUM_W'(cnt_reg);
    assign bad      = (cnt_reg == 4'd0) || (cnt_reg > 4'(MAX_BYTES))
                      || (end_sum > SUM_W'(BLOCK_BYTES));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg <= address[ADDR_BITS-1:0];
            wr_reg   <= is_write;
            cnt_reg  <= byte_count;
        end
    end

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            match[w]   = meta_rd[w][META_W-1] && (tag_rd[w] == tag_cur);
            lru_key[w] = meta_rd[w][META_W-1] ? {1'b1, meta_rd[w][STAMP_W-1:0]} : '0;
        end
    end

    always_comb
    begin
        hit_any = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        victim   = '0;
        best_key = lru_key[0];
        for (int w = 1; w < WAYS; w++)
        begin
            if (lru_key[w] < best_key)
            begin
                victim   = WAY_W'(w);
                best_key = lru_key[w];
            end
        end
    end

    assign acc_next  = (acc_reg == STAMP_MAX) ? acc_reg : acc_reg + 1'b1;
    assign miss_next = (miss_reg == TOTAL_MAX) ? miss_reg : miss_reg + 1'b1;
    assign do_fill   = !bad && !hit_any && (!wr_reg || write_allocate_mode);
    assign update    = cmd.commit && !bad && (hit_any || do_fill);
    assign upd_way   = hit_any ? hit_way : victim;
    assign new_dirty = (hit_any && !wr_reg) ? meta_rd[hit_way][META_W-2]
                                            : !write_through_mode;
    assign meta_wdata = cmd.clear ? '0 : {1'b1, new_dirty, acc_next};
    assign waddr      = cmd.clear ? clr_cnt_reg : set_cur;

    always_comb
    begin
        if (bad)
        begin
            lat = '0;
        end
        else if (hit_any || do_fill)
        begin
            lat = 9'(bus_delay) + 9'(hit_delay);
        end
        else
        begin
            lat = 9'(bus_delay);
        end
    end

    assign vdirty    = do_fill && meta_rd[victim][META_W-1] && meta_rd[victim][META_W-2];
    assign lower     = !bad && (!hit_any || (wr_reg && write_through_mode));
    assign lsum_wide = {1'b0, lsum_reg} + (TOTAL_W + 1)'(lat);
    assign lsum_next = lsum_wide[TOTAL_W] ? TOTAL_MAX : lsum_wide[TOTAL_W-1:0];

    for (genvar g = 0; g < WAYS; g++)
    begin : g_way
        sacl_ram #(
            .WIDTH (TAG_W),
            .DEPTH (SETS)
        ) u_tag (
            .clk   (clk),
            .we    (update && do_fill && (victim == WAY_W'(g))),
            .waddr (set_cur),
            .wdata (tag_cur),
            .re    (cmd.capture),
            .raddr (set_in),
            .rdata (tag_rd[g])
        );

        sacl_ram #(
            .WIDTH (META_W),
            .DEPTH (SETS)
        ) u_meta (
            .clk   (clk),
            .we    (cmd.clear || (update && (upd_way == WAY_W'(g)))),
            .waddr (waddr),
            .wdata (meta_wdata),
            .re    (cmd.capture),
            .raddr (set_in),
            .rdata (meta_rd[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            acc_reg       <= '0;
            miss_reg      <= '0;
            lsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                if (!bad)
                begin
                    acc_reg  <= acc_next;
                    lsum_reg <= lsum_next;
                    if (!hit_any)
                    begin
                        miss_reg <= miss_next;
                    end
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_reg    <= !bad && hit_any;
            way_reg    <= (!bad && (hit_any || do_fill)) ? 2'(upd_way) : 2'd0;
            filled_reg <= do_fill;
            vdirty_reg <= vdirty;
            lower_reg  <= lower;
            lat_reg    <= lat;
            bad_reg    <= bad;
            if (bad)
            begin
                acc_out_reg  <= (acc_reg > STAMP_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                                 : acc_reg[TOTAL_W-1:0];
                miss_out_reg <= miss_reg;
                lsum_out_reg <= lsum_reg;
            end
            else
            begin
                acc_out_reg  <= (acc_next > STAMP_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                                  : acc_next[TOTAL_W-1:0];
                miss_out_reg <= hit_any ? miss_reg : miss_next;
                lsum_out_reg <= lsum_next;
            end
        end
    end

    assign sts.clear_last = (clr_cnt_reg == SET_IW'(SETS - 1));
    assign sts.out_valid  = out_valid_reg;

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign way_used     = way_reg;
    assign filled       = filled_reg;
    assign victim_dirty = vdirty_reg;
    assign lower_access = lower_reg;
    assign own_latency  = lat_reg;
    assign bad_access   = bad_reg;
    assign access_total = acc_out_reg;
    assign miss_total   = miss_out_reg;
    assign time_total   = lsum_out_reg;

endmodule

`default_nettype wire

@@ rtl/set_assoc_cache_lru_controller.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_controller: LRU tag and policy controller.
// A request is taken in the idle state, which reads the tag and metadata
// rows of the set; the look state matches ways, picks the victim and writes
// back once the result register is free; only then is a new request taken.
// After reset a clearing pass over every set zeroes valid, dirty and use
// stamps; requests are held off until it ends, configuration writes are not.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_lru_controller #(
    parameter int SETS        = 64,
    parameter int WAYS        = 4,
    parameter int BLOCK_BYTES = 64,
    parameter int ADDR_BITS   = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] address,
    input  wire logic        is_write,
    input  wire logic [3:0]  byte_count,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             hit,
    output logic [1:0]       way_used,
    output logic             filled,
    output logic             victim_dirty,
    output logic             lower_access,
    output logic [8:0]       own_latency,
    output logic             bad_access,
    output logic [31:0]      access_total,
    output logic [31:0]      miss_total,
    output logic [31:0]      time_total
);

    import sacl_pkg::*;

    logic       wt_reg;
    logic       wa_reg;
    logic [7:0] bus_reg;
    logic [7:0] hitd_reg;
    cmd_t       cmd;
    sts_t       sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wt_reg   <= 1'b0;
            wa_reg   <= 1'b1;
            bus_reg  <= '0;
            hitd_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WRITE_THROUGH:  wt_reg   <= cfg_data[0];
                CFG_WRITE_ALLOCATE: wa_reg   <= cfg_data[0];
                CFG_BUS_DELAY:      bus_reg  <= cfg_data;
                CFG_HIT_DELAY:      hitd_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    sacl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    sacl_dp #(
        .SETS        (SETS),
        .WAYS        (WAYS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .sts                 (sts),
        .write_through_mode  (wt_reg),
        .write_allocate_mode (wa_reg),
        .bus_delay           (bus_reg),
        .hit_delay           (hitd_reg),
        .address             (address),
        .is_write            (is_write),
        .byte_count          (byte_count),
        .out_stall           (out_stall),
        .out_valid           (out_valid),
        .hit                 (hit),
        .way_used            (way_used),
        .filled              (filled),
        .victim_dirty        (victim_dirty),
        .lower_access        (lower_access),
        .own_latency         (own_latency),
        .bad_access          (bad_access),
        .access_total        (access_total),
        .miss_total          (miss_total),
        .time_total          (time_total)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken while another is in flight");

    a_bad_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_access) |-> (!hit && !filled && !lower_access))
        else $error("malformed request reported activity");

    a_fill_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && filled) |-> (!hit && lower_access))
        else $error("fill reported on a hit");

endmodule

`default_nettype wire
